[hdl/mouse_packet_cursor_tracker_top_assert.svh]
// Assertion macros shared by the cursor tracker modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_TOP_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_TOP_ASSERT_SVH

// checked outside reset only
`define MPCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define MPCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/mpct_pkg.sv]
// Types, constants and codes for the mouse packet cursor tracker.
// No dependencies; every module of the block imports it.
package mpct_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_BITS   = 12;
  localparam int OUT_BITS   = 12;
  // signed working width for position plus delta
  localparam int SUM_W = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam int POS_X_INIT = 512;
  localparam int POS_Y_INIT = 384;
  localparam logic [COORD_BITS-1:0] POS_X_RST =
      (POS_X_INIT > int'(COORD_MAX)) ? COORD_MAX : COORD_BITS'(POS_X_INIT);
  localparam logic [COORD_BITS-1:0] POS_Y_RST =
      (POS_Y_INIT > int'(COORD_MAX)) ? COORD_MAX : COORD_BITS'(POS_Y_INIT);

  localparam logic [CFG_BITS-1:0] WIDTH_RST  = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0] HEIGHT_RST = CFG_BITS'(768);

  localparam logic [2:0] BUTTON_MASK = 3'h7;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    EV_MOVE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_LEFT  = 2'd1,
    BTN_RIGHT = 2'd2
  } which_button_e;

  typedef struct packed {
    logic [2:0]        button_bits;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
  } in_item_t;

  typedef struct packed {
    event_kind_e         event_kind;
    logic [OUT_BITS-1:0] cursor_x;
    logic [OUT_BITS-1:0] cursor_y;
    which_button_e       which_button;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] screen_width;
    logic [CFG_BITS-1:0] screen_height;
  } cfg_t;

  // one decoded packet waiting for the result sequencer
  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  left_chg;
    logic                  left_now;
    logic                  right_chg;
    logic                  right_now;
  } job_t;

endpackage

[hdl/mpct_cfg.sv]
// APB register file holding the screen bounds.
// Depends on mpct_pkg.
module mpct_cfg import mpct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_WIDTH:  cfg_d.screen_width  = pwdata[CFG_BITS-1:0];
        REG_HEIGHT: cfg_d.screen_height = pwdata[CFG_BITS-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= WIDTH_RST;
      cfg_q.screen_height <= HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = 32'(cfg_q.screen_width);
      REG_HEIGHT: prdata = 32'(cfg_q.screen_height);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/mpct_front.sv]
// Front end: accepts packets, updates cursor and button state, queues a job.
// Depends on mpct_pkg.
module mpct_front import mpct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                  left_q, left_d, right_q, right_d;
  logic [2:0]            buttons;
  logic                  accept;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                  input logic [CFG_BITS-1:0] bound);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] r;
    hi = signed'(SUM_W'(bound));
    if (hi > signed'(SUM_W'(COORD_MAX))) hi = signed'(SUM_W'(COORD_MAX));
    r = v;
    if (r < 0) r = '0;
    if (r > hi) r = hi;
    return r[COORD_BITS-1:0];
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign buttons    = in_data_i.button_bits & BUTTON_MASK;

  always_comb begin
    pos_x_d = clamp(signed'(SUM_W'(pos_x_q)) + SUM_W'(in_data_i.delta_x),
                    cfg_i.screen_width);
    pos_y_d = clamp(signed'(SUM_W'(pos_y_q)) - SUM_W'(in_data_i.delta_y),
                    cfg_i.screen_height);
    left_d  = buttons[0];
    right_d = buttons[1];
  end

  always_comb begin
    job_o.pos_x     = pos_x_d;
    job_o.pos_y     = pos_y_d;
    job_o.left_chg  = left_d != left_q;
    job_o.left_now  = left_d;
    job_o.right_chg = right_d != right_q;
    job_o.right_now = right_d;
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= POS_X_RST;
      pos_y_q <= POS_Y_RST;
      left_q  <= 1'b0;
      right_q <= 1'b0;
    end else if (accept) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

[hdl/mpct_fifo.sv]
// Short job queue between the packet front end and the result sequencer.
// Depends on mpct_pkg and the assertion macro header.
`include "mouse_packet_cursor_tracker_top_assert.svh"

module mpct_fifo import mpct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  input  logic pop_i,
  output job_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  job_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wptr_q, rptr_q;
  logic [Q_CW-1:0] count_q;

  function automatic logic [Q_AW-1:0] next_ptr(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = count_q == Q_CW'(Q_DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= next_ptr(wptr_q);
      if (pop_i)  rptr_q <= next_ptr(rptr_q);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `MPCT_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full job queue")
  `MPCT_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "pop from empty job queue")
  `MPCT_ASSERT_ALWAYS(a_count_bound, count_q <= Q_CW'(Q_DEPTH), "job count overflow")

endmodule

[hdl/mpct_back.sv]
// Result sequencer: turns each queued job into a move result and up to two
// button results, one per cycle unless stalled, into an output register.
// Depends on mpct_pkg and the assertion macro header.
`include "mouse_packet_cursor_tracker_top_assert.svh"

module mpct_back import mpct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  job_t      q_head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    PH_MOVE  = 3'b001,
    PH_LEFT  = 3'b010,
    PH_RIGHT = 3'b100
  } phase_e;

  phase_e    phase_q, phase_d;
  out_item_t out_q, res;
  logic      out_valid_q;
  logic      load;

  assign load = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    res.cursor_x     = OUT_BITS'(q_head_i.pos_x);
    res.cursor_y     = OUT_BITS'(q_head_i.pos_y);
    res.event_kind   = EV_MOVE;
    res.which_button = BTN_NONE;
    res.last_of_run  = 1'b1;
    phase_d          = PH_MOVE;
    case (phase_q)
      PH_MOVE: begin
        res.last_of_run = !q_head_i.left_chg && !q_head_i.right_chg;
        if (q_head_i.left_chg)       phase_d = PH_LEFT;
        else if (q_head_i.right_chg) phase_d = PH_RIGHT;
      end
      PH_LEFT: begin
        res.event_kind   = q_head_i.left_now ? EV_DOWN : EV_UP;
        res.which_button = BTN_LEFT;
        res.last_of_run  = !q_head_i.right_chg;
        if (q_head_i.right_chg) phase_d = PH_RIGHT;
      end
      PH_RIGHT: begin
        res.event_kind   = q_head_i.right_now ? EV_DOWN : EV_UP;
        res.which_button = BTN_RIGHT;
      end
      default: phase_d = PH_MOVE;
    endcase
  end

  assign pop_o = load && res.last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MOVE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a move that is not last must be followed by a button result of the same job
  `MPCT_ASSERT(a_move_then_button,
    (load && res.event_kind == EV_MOVE && !res.last_of_run) |=> (phase_q != PH_MOVE),
    "button result missing after move")

endmodule

[hdl/mouse_packet_cursor_tracker_top.sv]
// Mouse packet cursor tracker, top level.
// Depends on mpct_pkg, mpct_cfg, mpct_front, mpct_fifo, mpct_back.
//
// Each accepted packet moves the cursor by (dx, -dy), clamped to 0..screen
// bound, and yields a move result followed by a down/up result for the left
// and then the right button when that button changed. A packet is taken
// into a two-entry job queue whenever the queue has room, also while
// results are still pending; the result sequencer then issues one result
// per cycle while out_ready_i is high, so a packet yields 1 to 3 results
// (1 plus the number of changed buttons). Result fields are registered.
// There is no clearing pass after reset.
`include "mouse_packet_cursor_tracker_top_assert.svh"

module mouse_packet_cursor_tracker_top import mpct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  cfg_t cfg;
  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  mpct_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mpct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  mpct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mpct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `MPCT_ASSERT(a_accept_queued, (in_valid_i && in_ready_o) |=> !q_empty,
    "accepted packet not queued")

endmodule
